>>> design/sigma_clipped_mean_2d_defines.svh
// Assertion macros for the top file, which checks its own logic
`ifndef SIGMA_CLIPPED_MEAN_2D_DEFINES_SVH
`define SIGMA_CLIPPED_MEAN_2D_DEFINES_SVH

// Check a property on every clock edge outside reset
`define SCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define SCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/scm_pkg.sv
`default_nettype none
package scm_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int CmpW = (CntW > 7) ? CntW : 7;
  localparam int SumW = 24 + AddrW + 1;
  localparam int DistW = 50;
  localparam int SpreadW = DistW + AddrW;
  localparam int ThrW = SpreadW + 7;
  localparam int QuoW = ThrW;
  localparam int DivW = ThrW;
  localparam int DivCntW = $clog2(DivW + 1);

  localparam logic [0:0] RegClip = 1'b0;
  localparam logic [0:0] RegMinPts = 1'b1;
  localparam logic [6:0] ClipReset = 7'd9;
  localparam logic [6:0] MinPtsReset = 7'd3;

  // Divider jobs
  localparam logic [1:0] JobMean = 2'd0;
  localparam logic [1:0] JobVar = 2'd1;
  localparam logic [1:0] JobFin = 2'd2;

  typedef struct packed {
    logic signed [23:0] delta_y;
    logic signed [23:0] delta_x;
    logic last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic [6:0] inlier_count;
    logic set_status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_MEAN_START, ST_MEAN_WAIT, ST_SPREAD, ST_VAR_START, ST_VAR_WAIT,
    ST_CLIP, ST_FIN_START, ST_FIN_WAIT, ST_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;          // store the accepted request
    logic clear;         // drop the set
    logic div_mean;      // start x and y division by n
    logic div_var;       // start variance division
    logic div_fin;       // start inlier mean division
    logic scan_start;    // reset the store walk
    logic scan_run;      // advance the store walk
    logic scan_clip;     // the walk compares against the threshold
    logic out_load;      // capture the result
    logic too_few;       // result is the too-few status
  } scm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic set_small;
  } scm_sts_t;
endpackage
`default_nettype wire

>>> design/scm_ram.sv
`default_nettype none
module scm_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/scm_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle, signed by magnitude.
module scm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          is_signed,
  input  wire logic [scm_pkg::DivW-1:0]      num,
  input  wire logic [scm_pkg::CntW-1:0]      den,
  output logic      [scm_pkg::DivW-1:0]      quo,
  output logic                               busy
);
  import scm_pkg::*;

  logic [DivW-1:0]    rem_q;
  logic [DivW:0]      acc;
  logic [CntW-1:0]    dv;
  logic [DivCntW-1:0] cnt;
  logic               neg;
  logic [DivW:0]      trial;
  logic [DivW:0]      shifted;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    shifted = {acc[DivW-1:0], rem_q[DivW-1]};
    trial = shifted - {{(DivW + 1 - CntW){1'b0}}, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= DivCntW'(DivW);
      neg <= is_signed & num[DivW-1];
      rem_q <= (is_signed & num[DivW-1]) ? (~num + 1'b1) : num;
      acc <= '0;
      dv <= den;
    end else if (busy) begin
      if (trial[DivW]) begin
        acc <= shifted;
        rem_q <= {rem_q[DivW-2:0], 1'b0};
      end else begin
        acc <= trial;
        rem_q <= {rem_q[DivW-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == DivCntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = neg ? (~rem_q + 1'b1) : rem_q;
endmodule
`default_nettype wire

>>> design/scm_ctrl.sv
`default_nettype none
module scm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire logic              out_free,
  input  wire scm_pkg::scm_sts_t sts,
  output scm_pkg::scm_cmd_t      cmd,
  output scm_pkg::state_t        fsm_state
);
  import scm_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid & in_ready;
  assign fsm_state = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:       if (accept && in_last) state_next = ST_MEAN_START;
      ST_MEAN_START: state_next = sts.set_small ? ST_OUT : ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (sts.div_done) state_next = ST_SPREAD;
      ST_SPREAD:     if (sts.scan_done) state_next = ST_VAR_START;
      ST_VAR_START:  state_next = ST_VAR_WAIT;
      ST_VAR_WAIT:   if (sts.div_done) state_next = ST_CLIP;
      ST_CLIP:       if (sts.scan_done) state_next = ST_FIN_START;
      ST_FIN_START:  state_next = ST_FIN_WAIT;
      ST_FIN_WAIT:   if (sts.div_done) state_next = ST_OUT;
      ST_OUT:        if (out_free) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = accept;
      end
      ST_MEAN_START: begin
        cmd.div_mean = ~sts.set_small;
        cmd.scan_start = 1'b1;
      end
      ST_SPREAD:     cmd.scan_run = 1'b1;
      ST_VAR_START:  cmd.div_var = 1'b1;
      ST_VAR_WAIT:   cmd.scan_start = 1'b1;
      ST_CLIP: begin
        cmd.scan_run = 1'b1;
        cmd.scan_clip = 1'b1;
      end
      ST_FIN_START:  cmd.div_fin = 1'b1;
      ST_OUT: begin
        cmd.too_few = sts.set_small;
        cmd.out_load = out_free;
        cmd.clear = out_free;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> design/scm_dp.sv
`default_nettype none
module scm_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scm_pkg::scm_cmd_t   cmd,
  input  wire scm_pkg::in_item_t   in_item,
  input  wire logic [6:0]          clip_factor_sq,
  input  wire logic [6:0]          min_points,
  output scm_pkg::scm_sts_t        sts,
  output scm_pkg::out_item_t       result,
  output logic                     result_valid,
  input  wire logic                result_take
);
  import scm_pkg::*;

  logic signed [SumW-1:0] sum_x, sum_y, kx, ky;
  logic [CntW-1:0]        point_count, kept;
  logic [SpreadW-1:0]     spread_sum;
  logic [ThrW-1:0]        thr;
  logic signed [23:0]     mx, my;
  logic [AddrW:0]         rd_idx;
  logic                   rd_vld, rd_vld_q;
  logic [47:0]            rdata;
  logic                   fin_y;
  logic                   store_full;
  logic signed [23:0]     px, py;
  logic signed [24:0]     dx, dy;
  logic [49:0]            dxx, dyy;
  logic [DistW-1:0]       sq_dist;
  logic                   dist_vld;
  logic signed [23:0]     ex, ey;
  logic signed [23:0]     ex_q, ey_q;
  logic                   div_start, div_busy, div_busy_q, div_signed;
  logic [DivW-1:0]        div_num, quo;
  logic [CntW-1:0]        div_den;
  logic [1:0]             div_step;
  logic [1:0]             div_job;
  logic [ThrW-1:0]        var_q;
  logic signed [23:0]     fin_mx, fin_my;
  logic [6:0]             kept_sat;

  assign store_full = point_count == CntW'(MaxPoints);

  scm_ram #(.Width(48), .Depth(MaxPoints)) u_store (
    .clk(clk), .we(cmd.load & ~store_full), .waddr(point_count[AddrW-1:0]),
    .wdata({in_item.delta_y, in_item.delta_x}), .raddr(rd_idx[AddrW-1:0]), .rdata(rdata)
  );

  // Running sums and count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum_x <= '0;
      sum_y <= '0;
      point_count <= '0;
    end else if (cmd.load && !store_full) begin
      sum_x <= sum_x + SumW'(in_item.delta_x);
      sum_y <= sum_y + SumW'(in_item.delta_y);
      point_count <= point_count + 1'b1;
    end
  end

  assign sts.set_small = (point_count < CntW'(2)) ||
                         (CmpW'(min_points) > CmpW'(point_count));

  // Store walk: one address per cycle, registered read, a deviation stage, then a squaring stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_vld_q <= 1'b0;
      dist_vld <= 1'b0;
      rd_idx <= '0;
    end else if (cmd.scan_start) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
      rd_vld_q <= 1'b0;
      dist_vld <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld <= rd_idx < (AddrW + 1)'(point_count);
      if (rd_idx < (AddrW + 1)'(point_count)) rd_idx <= rd_idx + 1'b1;
      rd_vld_q <= rd_vld;
      dist_vld <= rd_vld_q;
    end
  end

  assign px = rdata[23:0];
  assign py = rdata[47:24];

  // Deviation from the mean, registered before squaring
  always_ff @(posedge clk) begin
    dx <= 25'(px) - 25'(mx);
    dy <= 25'(py) - 25'(my);
    ex <= px;
    ey <= py;
  end

  assign dxx = 50'(dx * dx);
  assign dyy = 50'(dy * dy);

  always_ff @(posedge clk) begin
    sq_dist <= dxx + dyy;
  end

  always_ff @(posedge clk) begin
    ex_q <= ex;
    ey_q <= ey;
  end

  assign sts.scan_done = cmd.scan_run && !rd_vld && !rd_vld_q && !dist_vld &&
                         rd_idx != '0;

  // Accumulate spread or inlier sums
  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.div_mean) begin
      spread_sum <= '0;
      kept <= '0;
      kx <= '0;
      ky <= '0;
    end else if (dist_vld && cmd.scan_run) begin
      if (!cmd.scan_clip) begin
        spread_sum <= spread_sum + SpreadW'(sq_dist);
      end else if (ThrW'(sq_dist) < thr) begin
        kept <= kept + 1'b1;
        kx <= kx + SumW'(ex_q);
        ky <= ky + SumW'(ey_q);
      end
    end
  end

  // Shared divider: mean x then y, variance, inlier x then y (all points if none are kept)
  always_comb begin
    div_signed = 1'b1;
    div_num = DivW'(sum_x);
    div_den = point_count;
    unique case (div_job)
      JobMean: begin
        div_num = fin_y ? DivW'(sum_y) : DivW'(sum_x);
      end
      JobVar: begin
        div_signed = 1'b0;
        div_num = DivW'(spread_sum);
        div_den = point_count - 1'b1;
      end
      default: begin
        div_den = (kept == '0) ? point_count : kept;
        if (kept == '0) div_num = fin_y ? DivW'(sum_y) : DivW'(sum_x);
        else div_num = fin_y ? DivW'(ky) : DivW'(kx);
      end
    endcase
  end

  scm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .is_signed(div_signed),
    .num(div_num), .den(div_den), .quo(quo), .busy(div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy_q <= 1'b0;
      div_step <= '0;
      fin_y <= 1'b0;
      div_job <= JobMean;
    end else begin
      div_busy_q <= div_busy;
      if (cmd.div_mean) begin
        div_job <= JobMean;
        fin_y <= 1'b0;
        div_step <= 2'd1;
      end else if (cmd.div_var) begin
        div_job <= JobVar;
        fin_y <= 1'b0;
        div_step <= 2'd2;
      end else if (cmd.div_fin) begin
        div_job <= JobFin;
        fin_y <= 1'b0;
        div_step <= 2'd1;
      end else if (div_busy_q && !div_busy) begin
        if (div_job == JobVar) begin
          var_q <= quo;
          div_step <= 2'd0;
        end else if (!fin_y) begin
          if (div_job == JobMean) mx <= quo[23:0];
          else fin_mx <= quo[23:0];
          fin_y <= 1'b1;
          div_step <= 2'd2;
        end else begin
          if (div_job == JobMean) my <= quo[23:0];
          else fin_my <= quo[23:0];
          div_step <= 2'd0;
        end
      end else if (div_step == 2'd2 && !div_busy) begin
        div_step <= 2'd3;
      end else if (div_step != 2'd0 && div_step != 2'd3) begin
        div_step <= 2'd3;
      end
    end
  end

  // Start on the command cycle's follow-up and after the first half
  assign div_start = (div_step == 2'd1 || div_step == 2'd2) && !div_busy && !div_busy_q;
  assign sts.div_done = div_busy_q && !div_busy && (div_job == JobVar || fin_y);

  // Threshold from the registered variance
  always_ff @(posedge clk) begin
    thr <= ThrW'(var_q * clip_factor_sq);
  end

  assign kept_sat = (kept == '0) ? 7'(point_count) : 7'(kept);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result.set_status <= cmd.too_few;
      result.inlier_count <= cmd.too_few ? 7'd0 : kept_sat;
      result.mean_x <= cmd.too_few ? 24'sd0 : fin_mx;
      result.mean_y <= cmd.too_few ? 24'sd0 : fin_my;
    end
  end
endmodule
`default_nettype wire

>>> design/sigma_clipped_mean_2d.sv
// Channel   Signals                         Moves
// in        in_valid/in_ready/in_item       one vector request
// out       out_valid/out_ready/out_item    one set result
// cfg       cfg_we/cfg_index/cfg_data       register write
// The last vector of a set starts two walks over the store and five passes of the
// bit-serial divider; a set below min_points or under two vectors skips them.
// Reset is synchronous and clears the sums. Input waits until the result is loaded;
// a stalled result holds in the output register until out_ready.
`default_nettype none
`include "sigma_clipped_mean_2d_defines.svh"
module sigma_clipped_mean_2d (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire scm_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scm_pkg::out_item_t       out_item,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [6:0]          cfg_data
);
  import scm_pkg::*;

  logic [6:0] clip_factor_sq, min_points;
  scm_cmd_t   cmd;
  scm_sts_t   sts;
  state_t     state;
  logic       out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_factor_sq <= ClipReset;
      min_points <= MinPtsReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegClip:   clip_factor_sq <= cfg_data;
        RegMinPts: min_points <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;

  scm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_item.last_point),
    .in_ready(in_ready), .out_free(out_free), .sts(sts), .cmd(cmd), .fsm_state(state)
  );

  scm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_item), .clip_factor_sq(clip_factor_sq),
    .min_points(min_points), .sts(sts), .result(out_item), .result_valid(out_valid),
    .result_take(out_ready)
  );

  `SCM_ASSERT(a_ready_only_load, in_ready |-> state == ST_LOAD, "ready outside load")
  `SCM_ASSERT(a_result_after_out, $rose(out_valid) |-> $past(state) == ST_OUT, "no closing")
  `SCM_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result survives reset")
endmodule
`default_nettype wire
